### rtl/core/tgs_pkg.sv
// Shared types and constants for the topic Gibbs token sampler.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tgs_pkg;
    // Table sizes. The index fields of the input stream are sized for these.
    localparam int TOPICS = 64;
    localparam int VOCAB  = 4096;
    localparam int DOCS   = 1024;

    localparam logic [2:0] ACT_SAMPLE = 3'd0;
    localparam logic [2:0] ACT_DOC    = 3'd1;
    localparam logic [2:0] ACT_WORD   = 3'd2;
    localparam logic [2:0] ACT_TOTAL  = 3'd3;
    localparam logic [2:0] ACT_SHAPE  = 3'd4;

    localparam logic [55:0] W56_MAX = {56{1'b1}};
    localparam logic [23:0] CNT_MAX = {24{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic load_wr;     // perform a load write
        logic dec_rd;      // read entries for the old topic
        logic dec_wr;      // write decremented counts
        logic scan_rd;     // read entries of the scan topic
        logic div_start;   // start the divider
        logic mul_lo;      // first partial product
        logic mul_hi;      // second partial product, accumulate
        logic thr_lo;      // threshold partial products
        logic thr_hi;
        logic srch;        // compare one running sum
        logic inc_rd;      // read entries for the new topic
        logic inc_wr;      // write incremented counts
        logic scan_next;   // advance scan topic
    } tgs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sample;
        logic div_done;
        logic scan_last;
        logic srch_last;
    } tgs_sts_t;
endpackage
`default_nettype wire

### rtl/core/tgs_ctrl.sv
// Controller state machine for the topic Gibbs token sampler.
// Depends on tgs_pkg; drives the datapath through tgs_cmd_t.
`default_nettype none
module tgs_ctrl
    import tgs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     out_busy,
    input  wire tgs_sts_t sts,
    output tgs_cmd_t      cmd,
    output logic          idle,
    output logic          out_load
);
    localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_DRD = 4'd2, S_DWR = 4'd3,
        S_SRD = 4'd4, S_DIV = 4'd5, S_MLO = 4'd6, S_MHI = 4'd7, S_TLO = 4'd8,
        S_THI = 4'd9, S_SRCH = 4'd10, S_IRD = 4'd11, S_IWR = 4'd12, S_OUT = 4'd13,
        S_DST = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_load = 1'b0;
        idle = (state_reg == S_IDLE);
        cmd.capture = idle && in_fire;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_LOAD;
            S_LOAD:
            begin
                if (sts.is_sample)
                begin
                    cmd.dec_rd = 1'b1;
                    state_next = S_DRD;
                end
                else
                begin
                    cmd.load_wr = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DRD:
            begin
                cmd.dec_wr = 1'b1;
                state_next = S_DWR;
            end
            S_DWR:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DST;
            end
            S_DST:   state_next = S_DIV;
            S_DIV:   if (sts.div_done) state_next = S_MLO;
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                if (sts.scan_last)
                    state_next = S_TLO;
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_DWR;
                end
            end
            S_TLO:
            begin
                cmd.thr_lo = 1'b1;
                state_next = S_THI;
            end
            S_THI:
            begin
                cmd.thr_hi = 1'b1;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                cmd.srch = 1'b1;
                if (sts.srch_last)
                    state_next = S_IRD;
            end
            S_IRD:
            begin
                cmd.inc_rd = 1'b1;
                state_next = S_IWR;
            end
            S_IWR:
            begin
                cmd.inc_wr = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/tgs_dp.sv
// Datapath of the topic Gibbs token sampler: tables, divider, multiplier, search.
// Depends on tgs_pkg; sequenced by tgs_ctrl.
`default_nettype none
module tgs_dp
    import tgs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tgs_cmd_t    cmd,
    output tgs_sts_t         sts,
    input  wire logic [2:0]  action,
    input  wire logic [11:0] word,
    input  wire logic [9:0]  doc,
    input  wire logic [5:0]  topic,
    input  wire logic [23:0] count_value,
    input  wire logic [31:0] shape_value,
    input  wire logic [31:0] random_draw,
    input  wire logic        last_token,
    input  wire logic [31:0] eta_prior,
    input  wire logic [12:0] vocab_in_use,
    input  wire logic [6:0]  topics_in_use,
    output logic [5:0]       new_topic,
    output logic             is_sample,
    output logic             sweep_done,
    output logic             count_clamped
);
    localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam int VW = (VOCAB > 1) ? $clog2(VOCAB) : 1;
    localparam int DW = (DOCS > 1) ? $clog2(DOCS) : 1;
    localparam int KW = $clog2(TOPICS + 1);

    logic [23:0] dt_mem [TOPICS*DOCS];
    logic [23:0] wt_mem [TOPICS*VOCAB];
    logic [23:0] tt_mem [TOPICS];
    logic [31:0] sh_mem [TOPICS*DOCS];
    logic [55:0] rw_mem [TOPICS];

    // Captured item.
    logic [2:0]  act_reg;
    logic [11:0] word_reg;
    logic [9:0]  doc_reg;
    logic [5:0]  topic_reg;
    logic [23:0] cval_reg;
    logic [31:0] sval_reg, rnd_reg;
    logic        last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;  word_reg <= word;  doc_reg <= doc;
            topic_reg <= topic; cval_reg <= count_value; sval_reg <= shape_value;
            rnd_reg <= random_draw; last_reg <= last_token;
        end
    end

    logic t_ok, d_ok, w_ok;
    assign t_ok = 32'(topic_reg) < 32'(TOPICS);
    assign d_ok = 32'(doc_reg) < 32'(DOCS);
    assign w_ok = 32'(word_reg) < 32'(VOCAB);
    assign sts.is_sample = (act_reg == ACT_SAMPLE);

    logic [KW-1:0] kuse;
    always_comb
    begin
        if (topics_in_use == 7'd0)
            kuse = KW'(1);
        else if (32'(topics_in_use) > 32'(TOPICS))
            kuse = KW'(TOPICS);
        else
            kuse = KW'(topics_in_use);
    end

    // Address selection: old topic, scan topic, or picked topic.
    logic [KW-1:0] k_reg;
    logic [TW-1:0] pick_reg;
    logic [TW-1:0] at;
    always_comb
    begin
        if (cmd.scan_rd)
            at = k_reg[TW-1:0];
        else if (cmd.inc_rd || cmd.inc_wr)
            at = pick_reg;
        else
            at = topic_reg[TW-1:0];
    end
    logic [TW+DW-1:0] a_dt;
    logic [TW+VW-1:0] a_wt;
    assign a_dt = {at, doc_reg[DW-1:0]};
    assign a_wt = {at, word_reg[VW-1:0]};

    logic [23:0] dt_q, wt_q, tt_q;
    logic [31:0] sh_q;
    logic        rd_any, inc_phase;
    assign rd_any = cmd.dec_rd || cmd.scan_rd || cmd.inc_rd;

    always_ff @(posedge clk)
    begin
        if (rd_any)
        begin
            dt_q <= dt_mem[a_dt];
            wt_q <= wt_mem[a_wt];
            tt_q <= tt_mem[at];
            sh_q <= sh_mem[a_dt];
        end
    end

    // Table writes.
    logic [23:0] dt_w, wt_w, tt_w;
    always_comb
    begin
        if (cmd.inc_wr)
        begin
            dt_w = (dt_q == CNT_MAX) ? dt_q : dt_q + 24'd1;
            wt_w = (wt_q == CNT_MAX) ? wt_q : wt_q + 24'd1;
            tt_w = (tt_q == CNT_MAX) ? tt_q : tt_q + 24'd1;
        end
        else
        begin
            dt_w = (dt_q == 24'd0) ? dt_q : dt_q - 24'd1;
            wt_w = (wt_q == 24'd0) ? wt_q : wt_q - 24'd1;
            tt_w = (tt_q == 24'd0) ? tt_q : tt_q - 24'd1;
        end
    end
    assign inc_phase = cmd.inc_wr;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            case (act_reg)
                ACT_DOC:   if (t_ok && d_ok) dt_mem[a_dt] <= cval_reg;
                ACT_WORD:  if (t_ok && w_ok) wt_mem[a_wt] <= cval_reg;
                ACT_TOTAL: if (t_ok) tt_mem[at] <= cval_reg;
                ACT_SHAPE: if (t_ok && d_ok) sh_mem[a_dt] <= sval_reg;
                default:   ;
            endcase
        end
        else if (cmd.dec_wr || cmd.inc_wr)
        begin
            if ((inc_phase || t_ok) && d_ok) dt_mem[a_dt] <= dt_w;
            if ((inc_phase || t_ok) && w_ok) wt_mem[a_wt] <= wt_w;
            if (inc_phase || t_ok) tt_mem[at] <= tt_w;
        end
    end

    logic clamp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_reg <= 1'b0;
        else if (cmd.capture)
            clamp_reg <= 1'b0;
        else if (cmd.dec_wr && t_ok)
            clamp_reg <= clamp_reg || (d_ok && dt_q == 24'd0)
                || (w_ok && wt_q == 24'd0) || (tt_q == 24'd0);
    end

    // Scan operands; out-of-range index entries read as zero. The numerator and
    // the multiplier can reach just above 2^40, so both carry 41 bits.
    logic [40:0] num_q16;
    logic [45:0] den_q16;
    logic [40:0] mult_q16;
    assign num_q16 = {1'b0, (w_ok ? wt_q : 24'd0), 16'd0} + 41'(eta_prior);
    assign den_q16 = 46'(vocab_in_use) * 46'(eta_prior) + {6'd0, tt_q, 16'd0};
    assign mult_q16 = {1'b0, (d_ok ? dt_q : 24'd0), 16'd0} + 41'(d_ok ? sh_q : 32'd0);

    // Restoring divider: 73-bit dividend num<<32, one quotient bit per cycle.
    logic [72:0] dvd_reg;
    logic [46:0] rem_reg;
    logic [45:0] den_reg;
    logic [40:0] mult_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [47:0] rem_sh;
    logic [47:0] rem_sub;
    assign rem_sh  = {rem_reg, dvd_reg[72]};
    assign rem_sub = rem_sh - {2'd0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 7'd73;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 7'd1;
            if (dcnt_reg == 7'd1)
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= {num_q16, 32'd0};
            rem_reg <= '0;
            den_reg <= den_q16;
            mult_reg <= mult_q16;
        end
        else if (dbusy_reg)
        begin
            if (!rem_sub[47])
            begin
                rem_reg <= rem_sub[46:0];
                dvd_reg <= {dvd_reg[71:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[46:0];
                dvd_reg <= {dvd_reg[71:0], 1'b0};
            end
        end
    end
    assign sts.div_done = !dbusy_reg && !cmd.div_start;

    // Quotient: dvd_reg holds it after 73 steps. Saturate above 64 bits.
    logic [63:0] ratio;
    assign ratio = (den_reg == 46'd0) ? 64'd0 :
                   (dvd_reg[72:64] != 9'd0) ? {64{1'b1}} : dvd_reg[63:0];

    // Weight = ratio(64) * mult(41) >> 16, split into two 32-bit ratio halves.
    logic [72:0] pp_reg;
    logic [72:0] pp_lo;
    assign pp_lo = 73'(ratio[31:0]) * 73'(mult_reg);
    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
            pp_reg <= pp_lo;
    end
    logic [104:0] prod;
    logic [55:0]  w;
    assign prod = {32'd0, pp_reg} + ({32'd0, 73'(ratio[63:32]) * 73'(mult_reg)} << 32);
    assign w = (prod[104:72] != 33'd0) ? W56_MAX : prod[71:16];

    logic [55:0] sum_reg;
    logic [56:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + {1'b0, w};
    always_ff @(posedge clk)
    begin
        if (cmd.dec_rd)
            sum_reg <= '0;
        else if (cmd.mul_hi)
        begin
            sum_reg <= sum_add[56] ? W56_MAX : sum_add[55:0];
            rw_mem[k_reg[TW-1:0]] <= sum_add[56] ? W56_MAX : sum_add[55:0];
        end
    end

    assign sts.scan_last = (k_reg == kuse - KW'(1));

    // Threshold = rnd * sum >> 32, in two 32x28 partial products.
    logic [59:0] tp_reg;
    logic [87:0] thr_full;
    logic [55:0] thr_reg;
    assign thr_full = {28'd0, tp_reg} + ({28'd0, 60'(rnd_reg) * 60'(sum_reg[55:28])} << 28);
    always_ff @(posedge clk)
    begin
        if (cmd.thr_lo)
            tp_reg <= 60'(rnd_reg) * 60'(sum_reg[27:0]);
        if (cmd.thr_hi)
            thr_reg <= thr_full[87:32];
    end

    // Linear search, one running sum per cycle, memory read registered.
    logic [55:0] rw_q;
    logic        found_reg;
    always_ff @(posedge clk)
    begin
        rw_q <= rw_mem[(cmd.srch && !cmd.thr_hi) ? k_reg[TW-1:0] : {TW{1'b0}}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            pick_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.dec_rd)
            k_reg <= '0;
        else if (cmd.scan_next)
            k_reg <= k_reg + KW'(1);
        else if (cmd.thr_lo)
        begin
            k_reg <= KW'(1);
            found_reg <= 1'b0;
            pick_reg <= TW'(kuse - KW'(1));
        end
        else if (cmd.srch)
        begin
            // rw_q holds entry k_reg-1.
            if (!found_reg && rw_q >= thr_reg)
            begin
                found_reg <= 1'b1;
                pick_reg <= TW'(k_reg - KW'(1));
            end
            k_reg <= k_reg + KW'(1);
        end
    end
    assign sts.srch_last = (k_reg == kuse);

    assign new_topic     = sts.is_sample ? 6'(pick_reg) : 6'd0;
    assign is_sample     = sts.is_sample;
    assign sweep_done    = sts.is_sample && last_reg;
    assign count_clamped = sts.is_sample && clamp_reg;
endmodule
`default_nettype wire

### rtl/core/topic_gibbs_token_sampler.sv
// Top level of the topic Gibbs token sampler: stream ports, APB registers,
// output register. Depends on tgs_pkg, tgs_ctrl and tgs_dp.
`default_nettype none
// The block takes one transaction at a time. A load transaction (actions 1 to 4)
// writes one table entry and returns an all-zero result through the output
// register; the block is ready again once that result is loaded. A sample
// transaction decrements the old topic's counts, then for each topic in use
// reads the tables, runs a restoring divider of 73 one-bit steps and a two-step
// multiply-accumulate, then searches the running sums one entry a cycle and
// increments the picked topic's counts. A result waits to be loaded while the
// previous one is still held by a stalled output. Tables need no clearing pass:
// unwritten entries are undefined and must be loaded before use. Configuration
// is to be written over APB only while idle; the block itself does not enforce
// this.
module topic_gibbs_token_sampler
    import tgs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: action[2:0], word[14:3], doc[24:15], topic[30:25],
    // count_value[54:31], shape_value[86:55], random_draw[118:87], zero fill
    input  wire logic [119:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: new_topic[5:0], count_clamped[6], zero fill
    output logic [7:0]        m_tdata,
    // tuser: is_sample
    output logic              m_tuser,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [3:0] ADDR_ETA = 4'h0, ADDR_VOCAB = 4'h4, ADDR_TOPICS = 4'h8;

    logic [31:0] eta_reg;
    logic [12:0] vocab_reg;
    logic [6:0]  topics_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg <= 32'd655;
            vocab_reg <= 13'd4096;
            topics_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_ETA:    eta_reg <= pwdata;
                ADDR_VOCAB:  vocab_reg <= pwdata[12:0];
                ADDR_TOPICS: topics_reg <= pwdata[6:0];
                default:     ;
            endcase
        end
    end
    always_comb
    begin
        unique case (paddr)
            ADDR_ETA:    prdata = eta_reg;
            ADDR_VOCAB:  prdata = {19'd0, vocab_reg};
            ADDR_TOPICS: prdata = {25'd0, topics_reg};
            default:     prdata = 32'd0;
        endcase
    end

    tgs_cmd_t cmd;
    tgs_sts_t sts;
    logic idle, out_load, in_fire;
    logic [5:0] nt;
    logic smp, swd, clp;

    assign s_tready = idle;
    assign in_fire = s_tvalid && s_tready;

    tgs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
        .sts(sts), .cmd(cmd), .idle(idle), .out_load(out_load)
    );

    tgs_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .action(s_tdata[2:0]), .word(s_tdata[14:3]), .doc(s_tdata[24:15]),
        .topic(s_tdata[30:25]), .count_value(s_tdata[54:31]),
        .shape_value(s_tdata[86:55]), .random_draw(s_tdata[118:87]),
        .last_token(s_tlast), .eta_prior(eta_reg), .vocab_in_use(vocab_reg),
        .topics_in_use(topics_reg), .new_topic(nt), .is_sample(smp),
        .sweep_done(swd), .count_clamped(clp)
    );

    // Output register; the controller waits for it to drain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (out_load)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata <= {1'b0, clp, nt};
            m_tuser <= smp;
            m_tlast <= swd;
        end
    end
endmodule
`default_nettype wire

### tb/topic_gibbs_token_sampler_tb.sv
// Self-checking testbench for topic_gibbs_token_sampler: loads the count and shape
// tables, samples tokens under several register settings and checks every result.
// Depends on tgs_pkg and the topic_gibbs_token_sampler RTL.
`default_nettype none
module topic_gibbs_token_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tgs_pkg::*;

    localparam int N_TOPICS = 64;
    localparam int N_VOCAB  = 4096;
    localparam int N_DOCS   = 1024;

    // Register byte addresses on the APB port.
    localparam logic [3:0] REG_ETA    = 4'h0;
    localparam logic [3:0] REG_VOCAB  = 4'h4;
    localparam logic [3:0] REG_TOPICS = 4'h8;

    // Action codes that the block does not define; they must leave state alone.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    // A stretch of this many cycles without any transaction ends the run.
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [2:0]  action;
        logic [11:0] word;
        logic [9:0]  doc;
        logic [5:0]  topic;
        logic [23:0] count_value;
        logic [31:0] shape_value;
        logic [31:0] random_draw;
        logic        last_token;
    } token_t;

    typedef struct {
        logic [5:0] new_topic;
        logic       is_sample;
        logic       sweep_done;
        logic       count_clamped;
    } topic_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    topic_gibbs_token_sampler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block's registers and tables. The tables are sparse:
    // only entries that a load transaction has written ever exist here.
    logic [31:0] eta_shadow    = 32'd655;
    logic [12:0] vocab_shadow  = 13'd4096;
    logic [6:0]  topics_shadow = 7'd64;
    logic [23:0] doc_topic_cnt  [int];
    logic [23:0] word_topic_cnt [int];
    logic [23:0] topic_total    [int];
    logic [31:0] shape_entry    [int];

    token_t        pending_tokens [$];
    topic_result_t expected_topics [$];
    token_t        token_on_bus;

    int fail_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit gaps_off = 1'b0;

    // Tokens are only sampled for a few words and documents whose entries are
    // loaded for every topic, so the scan never reads an undefined entry.
    logic [11:0] ws_words [3] = '{12'd0, 12'd4095, 12'd2730};
    logic [9:0]  ws_docs  [2] = '{10'd0, 10'd1023};

    // Work out the result of one token and update the shadow tables the same
    // way the block does: remove the token, build the Q24.32 running sums,
    // search them against the scaled draw, then add the token back.
    function automatic topic_result_t predict_token(token_t t);
        topic_result_t r;
        int          kuse;
        int          pick;
        logic [55:0] run_sum [N_TOPICS];
        logic [55:0] total_w;
        logic [55:0] w;
        logic [55:0] thr;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mult;
        logic [63:0] ratio;
        logic [127:0] wide;
        int dkey;
        int wkey;
        r = '{default: 1'b0};
        dkey = int'(t.topic) * N_DOCS + int'(t.doc);
        wkey = int'(t.topic) * N_VOCAB + int'(t.word);
        case (t.action)
            ACT_DOC:   doc_topic_cnt[dkey] = t.count_value;
            ACT_WORD:  word_topic_cnt[wkey] = t.count_value;
            ACT_TOTAL: topic_total[int'(t.topic)] = t.count_value;
            ACT_SHAPE: shape_entry[dkey] = t.shape_value;
            default:   ;
        endcase
        if (t.action != ACT_SAMPLE)
            return r;

        r.is_sample = 1'b1;
        r.sweep_done = t.last_token;
        if (doc_topic_cnt[dkey] == 0) r.count_clamped = 1'b1;
        else doc_topic_cnt[dkey]--;
        if (word_topic_cnt[wkey] == 0) r.count_clamped = 1'b1;
        else word_topic_cnt[wkey]--;
        if (topic_total[int'(t.topic)] == 0) r.count_clamped = 1'b1;
        else topic_total[int'(t.topic)]--;

        kuse = (topics_shadow == 0) ? 1 : (topics_shadow > N_TOPICS) ? N_TOPICS
                                                                      : int'(topics_shadow);
        total_w = '0;
        for (int k = 0; k < kuse; k++)
        begin
            num = {24'd0, word_topic_cnt[k * N_VOCAB + int'(t.word)], 16'd0}
                  + 64'(eta_shadow);
            den = 64'(vocab_shadow) * 64'(eta_shadow)
                  + {24'd0, topic_total[k], 16'd0};
            mult = {24'd0, doc_topic_cnt[k * N_DOCS + int'(t.doc)], 16'd0}
                   + 64'(shape_entry[k * N_DOCS + int'(t.doc)]);
            // A zero denominator gives that topic no weight at all.
            if (den == 0)
                ratio = '0;
            else
            begin
                wide = {32'd0, num, 32'd0} / {64'd0, den};
                ratio = (wide[127:64] != 0) ? {64{1'b1}} : wide[63:0];
            end
            wide = {64'd0, ratio} * {64'd0, mult};
            w = (wide[127:72] != 0) ? W56_MAX : wide[71:16];
            if (w > W56_MAX - total_w) total_w = W56_MAX;
            else total_w = total_w + w;
            run_sum[k] = total_w;
        end

        wide = {96'd0, t.random_draw} * {72'd0, total_w};
        thr = wide[87:32];
        pick = kuse - 1;
        for (int k = 0; k < kuse; k++)
        begin
            if (run_sum[k] >= thr)
            begin
                pick = k;
                break;
            end
        end

        dkey = pick * N_DOCS + int'(t.doc);
        wkey = pick * N_VOCAB + int'(t.word);
        if (doc_topic_cnt[dkey] != CNT_MAX) doc_topic_cnt[dkey]++;
        if (word_topic_cnt[wkey] != CNT_MAX) word_topic_cnt[wkey]++;
        if (topic_total[pick] != CNT_MAX) topic_total[pick]++;
        r.new_topic = 6'(pick);
        return r;
    endfunction

    // Stream driver. A token offered on the bus is held until the block takes
    // it; the prediction is made at the edge where that transaction happens,
    // so its order always matches the block's.
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
                expected_topics.push_back(predict_token(token_on_bus));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_tokens.size() > 0)
            begin
                token_on_bus = pending_tokens.pop_front();
                s_tdata <= {1'b0, token_on_bus.random_draw, token_on_bus.shape_value,
                            token_on_bus.count_value, token_on_bus.topic, token_on_bus.doc,
                            token_on_bus.word, token_on_bus.action};
                s_tlast <= token_on_bus.last_token;
                s_tvalid <= 1'b1;
                // Now and then switch between gapped traffic and back-to-back runs.
                if ($urandom_range(0, 39) == 0)
                    gaps_off = !gaps_off;
                send_gap <= gaps_off ? 0 : $urandom_range(0, 5);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk)
    begin
        topic_result_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_topics.size() == 0)
                begin
                    $display("%0t: unexpected result topic=%0d clamped=%0b sample=%0b done=%0b",
                             $time, m_tdata[5:0], m_tdata[6], m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_topics.pop_front();
                    if (m_tdata[5:0] !== exp_r.new_topic || m_tdata[6] !== exp_r.count_clamped
                        || m_tuser !== exp_r.is_sample || m_tlast !== exp_r.sweep_done
                        || m_tdata[7] !== 1'b0)
                    begin
                        $display("%0t: mismatch expected topic=%0d clamped=%0b sample=%0b done=%0b",
                                 $time, exp_r.new_topic, exp_r.count_clamped,
                                 exp_r.is_sample, exp_r.sweep_done);
                        $display("%0t:          actual   topic=%0d clamped=%0b sample=%0b done=%0b",
                                 $time, m_tdata[5:0], m_tdata[6], m_tuser, m_tlast);
                        fail_count++;
                    end
                end
                recv_stall = gaps_off ? 0 : $urandom_range(0, 5);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: a long run of cycles without any transaction means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL topic_gibbs_token_sampler");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_register(input logic [3:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_ETA:    eta_shadow = value;
            REG_VOCAB:  vocab_shadow = value[12:0];
            REG_TOPICS: topics_shadow = value[6:0];
            default:    ;
        endcase
    endtask

    task automatic set_registers(input logic [31:0] eta, input logic [31:0] vocab,
                                 input logic [31:0] topics);
        write_register(REG_ETA, eta);
        write_register(REG_VOCAB, vocab);
        write_register(REG_TOPICS, topics);
    endtask

    // Wait until every token has been taken and every result has come back,
    // then give the block time to settle before the registers move.
    // The clock edge after the queue empties lets the last token reach the bus.
    task automatic drain;
        wait (pending_tokens.size() == 0);
        @(posedge clk);
        wait (!s_tvalid && expected_topics.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    function automatic token_t base_token(logic [2:0] action, logic [11:0] word,
                                          logic [9:0] doc, logic [5:0] topic);
        token_t t;
        t.action = action;
        t.word = word;
        t.doc = doc;
        t.topic = topic;
        t.count_value = 24'($urandom);
        t.shape_value = $urandom;
        t.random_draw = $urandom;
        t.last_token = 1'($urandom);
        return t;
    endfunction

    // A token from the loaded working set with a random old topic and draw.
    function automatic token_t random_sample();
        token_t t;
        t = base_token(ACT_SAMPLE, ws_words[$urandom_range(0, 2)],
                       ws_docs[$urandom_range(0, 1)], 6'($urandom));
        case ($urandom_range(0, 9))
            0: t.random_draw = '0;
            1: t.random_draw = '1;
            default: ;
        endcase
        t.last_token = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    // A table load, half of them aimed at the working set so the sampled
    // counts keep moving; a few carry an undefined action code.
    function automatic token_t random_load();
        token_t t;
        t = base_token(3'($urandom_range(ACT_DOC, ACT_SHAPE)), 12'($urandom),
                       10'($urandom), 6'($urandom));
        if ($urandom_range(0, 1) == 0)
        begin
            t.word = ws_words[$urandom_range(0, 2)];
            t.doc = ws_docs[$urandom_range(0, 1)];
        end
        case ($urandom_range(0, 7))
            0:       t.count_value = CNT_MAX;
            1, 2:    t.count_value = 24'($urandom);
            default: t.count_value = 24'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 7) != 0)
            t.shape_value = $urandom_range(0, 32'h40000);
        if ($urandom_range(0, 19) == 0)
            t.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        return t;
    endfunction

    function automatic token_t load_token(logic [2:0] action, logic [11:0] word,
                                          logic [9:0] doc, logic [5:0] topic,
                                          logic [23:0] count, logic [31:0] shape);
        token_t t;
        t = base_token(action, word, doc, topic);
        t.count_value = count;
        t.shape_value = shape;
        return t;
    endfunction

    initial
    begin
        token_t t;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every entry that a sample in the working set will read.
        for (int k = 0; k < N_TOPICS; k++)
        begin
            pending_tokens.push_back(load_token(ACT_TOTAL, 12'($urandom), 10'($urandom),
                                                6'(k), 24'($urandom_range(0, 3)), 32'd0));
            foreach (ws_words[i])
                pending_tokens.push_back(load_token(ACT_WORD, ws_words[i], 10'($urandom),
                                                    6'(k), 24'($urandom_range(0, 3)), 32'd0));
            foreach (ws_docs[i])
            begin
                pending_tokens.push_back(load_token(ACT_DOC, 12'($urandom), ws_docs[i],
                                                    6'(k), 24'($urandom_range(0, 3)), 32'd0));
                pending_tokens.push_back(load_token(ACT_SHAPE, 12'($urandom), ws_docs[i],
                                                    6'(k), 24'd0,
                                                    $urandom_range(0, 32'h20000)));
            end
        end

        // Directed: counts at their top so the increment saturates; a draw of
        // zero forces topic 0, which then gets the increment.
        pending_tokens.push_back(load_token(ACT_DOC, 12'd0, 10'd0, 6'd0, CNT_MAX, '0));
        pending_tokens.push_back(load_token(ACT_WORD, 12'd0, 10'd0, 6'd0, CNT_MAX, '0));
        pending_tokens.push_back(load_token(ACT_TOTAL, 12'd0, 10'd0, 6'd0, CNT_MAX, '0));
        pending_tokens.push_back(load_token(ACT_SHAPE, 12'd0, 10'd0, 6'd0, '0, '1));
        pending_tokens.push_back(load_token(ACT_SHAPE, 12'd4095, 10'd1023, 6'd63, '0, '0));
        t = base_token(ACT_SAMPLE, 12'd0, 10'd0, 6'd5);
        t.random_draw = '0;
        t.last_token = 1'b0;
        pending_tokens.push_back(t);
        // Old topic with all counts at zero: the decrements clamp.
        pending_tokens.push_back(load_token(ACT_DOC, 12'd0, 10'd1023, 6'd63, '0, '0));
        pending_tokens.push_back(load_token(ACT_WORD, 12'd4095, 10'd0, 6'd63, '0, '0));
        pending_tokens.push_back(load_token(ACT_TOTAL, 12'd0, 10'd0, 6'd63, '0, '0));
        t = base_token(ACT_SAMPLE, 12'd4095, 10'd1023, 6'd63);
        t.random_draw = '1;
        t.last_token = 1'b1;
        pending_tokens.push_back(t);
        // Undefined action codes change nothing.
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
            pending_tokens.push_back(base_token(3'(a), 12'($urandom), 10'($urandom),
                                                6'($urandom)));
        pending_tokens.push_back(random_sample());
        drain();

        // Zero prior with a vocabulary of one: topics with a zero total
        // have a zero denominator.
        set_registers(32'd0, 32'd1, 32'd3);
        for (int i = 0; i < 20; i++)
            pending_tokens.push_back(($urandom_range(0, 2) == 0) ? random_load()
                                                                  : random_sample());
        drain();

        // Largest prior, vocabulary zero, and zero topics in use (taken as one).
        set_registers(32'hFFFF_FFFF, 32'd0, 32'd0);
        for (int i = 0; i < 20; i++)
            pending_tokens.push_back(($urandom_range(0, 2) == 0) ? random_load()
                                                                  : random_sample());
        drain();

        // Topics in use above the table size are taken as the full table.
        set_registers(32'h0001_0000, 32'd4096, 32'd127);
        for (int i = 0; i < 8; i++)
            pending_tokens.push_back(($urandom_range(0, 1) == 0) ? random_load()
                                                                  : random_sample());
        drain();

        // Random settings with few topics keep most samples short.
        for (int p = 0; p < 8; p++)
        begin
            set_registers(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h10000),
                          $urandom_range(1, 4096), $urandom_range(2, 8));
            for (int i = 0; i < 110; i++)
                pending_tokens.push_back(($urandom_range(0, 4) < 2) ? random_load()
                                                                     : random_sample());
            drain();
        end

        if (fail_count == 0)
            $display("PASS topic_gibbs_token_sampler");
        else
            $display("FAIL topic_gibbs_token_sampler");
        $finish;
    end
endmodule
`default_nettype wire

### topic_gibbs_token_sampler.f
rtl/core/tgs_pkg.sv
rtl/core/tgs_ctrl.sv
rtl/core/tgs_dp.sv
rtl/core/topic_gibbs_token_sampler.sv
tb/topic_gibbs_token_sampler_tb.sv
